// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl files; only the top-level file includes them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_CLK(name, clk, rst, prop)
`define ASSERT_NEVER(name, clk, rst, cond)

`endif

`endif

// ===== rtl/gesd_pkg.sv =====
// shared types and constants for the grouped exact span dedup block
package gesd_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 256;

   localparam int GROUP_W   = 32;
   localparam int GENOME_W  = 32;
   localparam int EXON_W    = 16;
   localparam int START_W   = 32;
   localparam int END_W     = 32;
   localparam int INDEX_W   = 9;

   // request tdata layout, lowest field first
   localparam int GROUP_LSB  = 0;
   localparam int GENOME_LSB = GROUP_LSB + GROUP_W;
   localparam int EXON_LSB   = GENOME_LSB + GENOME_W;
   localparam int START_LSB  = EXON_LSB + EXON_W;
   localparam int END_LSB    = START_LSB + START_W;
   localparam int REQ_BITS   = END_LSB + END_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;

   // response tdata layout
   localparam int RSP_BITS   = 2 + INDEX_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   typedef struct packed {
      logic [GENOME_W-1:0] genome_id;
      logic [EXON_W-1:0]   exon_count;
      logic [START_W-1:0]  span_start;
      logic [END_W-1:0]    span_end;
   } gesd_entry_type;

   localparam int ENTRY_W = $bits(gesd_entry_type);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE
   } gesd_state_type;

endpackage

// ===== rtl/gesd_table.sv =====
// record table memory, one write port and one registered read port
module gesd_table import gesd_pkg::*; #(
   parameter int DEPTH  = DEFAULT_TABLE_DEPTH,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  gesd_entry_type      wr_data,
   input  logic [ADDR_W-1:0]   rd_addr,
   output gesd_entry_type      rd_data
);

   gesd_entry_type mem_ff [DEPTH];
   gesd_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/grouped_exact_span_dedup.sv =====
// top level: drops exact duplicate alignment records within a group
// each request is compared with the stored entries of its group, stopping on a match;
//   the scan reads one entry a cycle through the single read port of the table; a decide
//   step registers the response, holding off the next request while the output is stalled
// reset: synchronous, clears group (to all ones), count, fsm and response valid;
//   table contents are not cleared, only entries below the count are ever read
`include "assert_macros.svh"

module grouped_exact_span_dedup import gesd_pkg::*; #(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // group_id[31:0], genome_id[63:32], exon_count[79:64],
   // span_start[111:80], span_end[143:112]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // keep[0], table_full[1], entry_index[10:2], zero fill above
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // table address and count widths follow the depth
   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   // control state
   gesd_state_type        state_ff, state_in;
   logic [GROUP_W-1:0]    group_ff, group_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      issue_ff, issue_in;
   logic                  pend_ff, pend_in;
   logic                  dup_ff, dup_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // payload
   gesd_entry_type        item_ff, item_in;
   logic                  rsp_keep_ff, rsp_keep_in;
   logic                  rsp_full_ff, rsp_full_in;
   logic [INDEX_W-1:0]    rsp_index_ff, rsp_index_in;

   // table port signals
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [ADDR_W-1:0]     rd_addr;
   gesd_entry_type        rd_data;

   logic                  req_fire;
   logic                  rsp_free;
   logic                  new_group;
   logic                  issue;
   logic                  hit;
   logic                  store;
   logic [CNT_W+INDEX_W-1:0] index_ext;
   gesd_entry_type        req_entry;
   logic [GROUP_W-1:0]    req_group;

   // unpack the request
   assign req_group            = req_tdata[GROUP_LSB +: GROUP_W];
   assign req_entry.genome_id  = req_tdata[GENOME_LSB +: GENOME_W];
   assign req_entry.exon_count = req_tdata[EXON_LSB +: EXON_W];
   assign req_entry.span_start = req_tdata[START_LSB +: START_W];
   assign req_entry.span_end   = req_tdata[END_LSB +: END_W];

   // one request in flight at a time; the response register frees the input side
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign new_group  = (req_group != group_ff);

   // scan: address goes out one cycle, data compared the next
   assign hit   = pend_ff && (rd_data == item_ff);
   assign issue = (state_ff == ST_SCAN) && (issue_ff < count_ff) && !hit;
   assign rd_addr = issue_ff[ADDR_W-1:0];

   // a fresh record is stored unless the table is full
   assign store   = !dup_ff && (count_ff != DEPTH_CNT);
   assign wr_en   = (state_ff == ST_DECIDE) && rsp_free && store;
   assign wr_addr = count_ff[ADDR_W-1:0];

   // entry index is the count masked to its field width
   assign index_ext = {{INDEX_W{1'b0}}, count_in};

   gesd_table #(
      .DEPTH  (TABLE_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (item_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // done on a match, or once every stored entry has been compared
            if (hit || (!issue && !pend_ff)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      group_in     = group_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      pend_in      = 1'b0;
      dup_in       = dup_ff;
      item_in      = item_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_keep_in  = rsp_keep_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_index_in = rsp_index_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               // a change of group empties the table
               group_in = req_group;
               if (new_group) begin
                  count_in = '0;
               end
               item_in  = req_entry;
               issue_in = '0;
               dup_in   = 1'b0;
            end
         end
         ST_SCAN: begin
            pend_in = issue;
            if (issue) begin
               issue_in = issue_ff + CNT_W'(1);
            end
            if (hit) begin
               dup_in = 1'b1;
            end
         end
         ST_DECIDE: begin
            if (rsp_free) begin
               count_in     = count_ff + CNT_W'(store);
               rsp_valid_in = 1'b1;
               rsp_keep_in  = !dup_ff;
               rsp_full_in  = !dup_ff && !store;
               rsp_index_in = index_ext[INDEX_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         group_ff     <= '1;
         count_ff     <= '0;
         issue_ff     <= '0;
         pend_ff      <= 1'b0;
         dup_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         group_ff     <= group_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         dup_ff       <= dup_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      rsp_keep_ff  <= rsp_keep_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_index_ff <= rsp_index_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_BITS){1'b0}},
                        rsp_index_ff, rsp_full_ff, rsp_keep_ff};

   // count never runs past the table depth
   `ASSERT_NEVER(a_count_bound, clock, reset, count_ff > DEPTH_CNT)
   // a table write always grows the count by one
   `ASSERT_CLK(a_write_count, clock, reset, wr_en |=> (count_ff == $past(count_ff) + CNT_W'(1)))
   // a new response only comes out of the decide step
   `ASSERT_CLK(a_rsp_source, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == ST_DECIDE))
   // a dropped duplicate never reports a full table
   `ASSERT_NEVER(a_drop_not_full, clock, reset, rsp_valid_ff && !rsp_keep_ff && rsp_full_ff)

endmodule
